### rtl/ordered_set_table_assert.svh
// Assertion macros used by the checker of the ordered set table.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ORDERED_SET_TABLE_ASSERT_SVH
`define ORDERED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OST_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ordered_set_table: check failed");

// Next-cycle implication, disabled while reset is high.
`define OST_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ordered_set_table: check failed");

`endif

### rtl/ost_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the ordered set table.
// Used by the front, the back, the top level and the checker.
package ost_pkg;

   localparam int OST_CAPACITY    = 16;
   localparam int OST_IDX_W       = $clog2(OST_CAPACITY);
   localparam int OST_COUNT_W     = $clog2(OST_CAPACITY + 1);
   localparam int OST_VALUE_W     = 32;
   localparam int OST_POS_W       = 4;
   localparam int OST_KIND_W      = 2;
   localparam int OST_STATUS_W    = 2;
   localparam int OST_QUEUE_DEPTH = 2;

   localparam logic [OST_KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [OST_KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [OST_KIND_W-1:0] KIND_SEARCH = 2'd2;
   localparam logic [OST_KIND_W-1:0] KIND_READ   = 2'd3;

   localparam logic [OST_STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [OST_STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [OST_STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [OST_STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic                   is_add;
      logic                   is_remove;
      logic                   is_search;
      logic                   is_read;
      logic [OST_VALUE_W-1:0] value;
      logic [OST_POS_W-1:0]   position;
   } cmd_type;

endpackage

### rtl/ost_front.sv
`timescale 1ns / 1ps
// Request front end: accepts items, decodes the kind and queues commands.
// Depends on ost_pkg for the command struct and the kind codes.
module ost_front import ost_pkg::*; #(
   parameter int QUEUE_DEPTH = OST_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OST_KIND_W-1:0]  req_kind,
   input  logic [OST_VALUE_W-1:0] req_value,
   input  logic [OST_POS_W-1:0]   req_position,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output cmd_type                cmd
);

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   cmd_type             cls;
   logic                push, pop;

   always_comb begin
      cls          = '0;
      cls.value    = req_value;
      cls.position = req_position;
      case (req_kind)
         KIND_ADD:    cls.is_add    = 1'b1;
         KIND_REMOVE: cls.is_remove = 1'b1;
         KIND_SEARCH: cls.is_search = 1'b1;
         KIND_READ:   cls.is_read   = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_ready = (fill_ff != FILL_FULL);
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/ost_back.sv
`timescale 1ns / 1ps
// Execution back end: element store, live count, parallel match and result register.
// Depends on ost_pkg for the command struct, sizes and status codes.
module ost_back import ost_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  cmd_type                 cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_success,
   output logic [OST_STATUS_W-1:0] rsp_status,
   output logic [OST_VALUE_W-1:0]  rsp_read_value,
   output logic [OST_COUNT_W-1:0]  rsp_element_count,
   output logic                    rsp_is_empty
);

   localparam logic [OST_COUNT_W-1:0] COUNT_FULL = OST_COUNT_W'(OST_CAPACITY);

   logic [OST_VALUE_W-1:0]  store_ff [OST_CAPACITY];
   logic [OST_COUNT_W-1:0]  count_ff, count_in;
   logic                    valid_ff, valid_in;
   logic                    success_ff, success_in;
   logic [OST_STATUS_W-1:0] status_ff, status_in;
   logic [OST_VALUE_W-1:0]  rdata_ff, rdata_in;
   logic [OST_CAPACITY-1:0] match;
   logic [OST_CAPACITY-1:0] shift_mask;
   logic                    found, full, read_ok, fire, do_write, do_shift;

   assign fire      = cmd_valid && cmd_ready;
   assign cmd_ready = !valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < OST_CAPACITY; i++) begin
         match[i] = (OST_COUNT_W'(i) < count_ff) && (store_ff[i] == cmd.value);
      end
   end

   assign found      = |match;
   assign shift_mask = ~(match - OST_CAPACITY'(1)) & {OST_CAPACITY{found}};
   assign full       = (count_ff == COUNT_FULL);
   assign read_ok    = (OST_COUNT_W'(cmd.position) < count_ff);

   always_comb begin
      count_in   = count_ff;
      success_in = 1'b0;
      status_in  = ST_MISS;
      rdata_in   = '0;
      do_write   = 1'b0;
      do_shift   = 1'b0;
      if (cmd.is_add) begin
         if (found) begin
            status_in = ST_MISS;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            success_in = 1'b1;
            status_in  = ST_OK;
            do_write   = 1'b1;
            count_in   = count_ff + OST_COUNT_W'(1);
         end
      end else if (cmd.is_remove) begin
         if (found) begin
            success_in = 1'b1;
            status_in  = ST_OK;
            do_shift   = 1'b1;
            count_in   = count_ff - OST_COUNT_W'(1);
         end
      end else if (cmd.is_search) begin
         if (found) begin
            success_in = 1'b1;
            status_in  = ST_OK;
         end
      end else if (cmd.is_read && read_ok) begin
         success_in = 1'b1;
         status_in  = ST_OK;
         rdata_in   = store_ff[cmd.position[OST_IDX_W-1:0]];
      end else begin
         status_in = ST_RANGE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         success_ff <= success_in;
         status_ff  <= status_in;
         rdata_ff   <= rdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && do_write) begin
         store_ff[count_ff[OST_IDX_W-1:0]] <= cmd.value;
      end
      for (int i = 0; i < OST_CAPACITY - 1; i++) begin
         if (fire && do_shift && shift_mask[i]) begin
            store_ff[i] <= store_ff[i+1];
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_success       = success_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_value    = rdata_ff;
   assign rsp_element_count = count_ff;
   assign rsp_is_empty      = (count_ff == '0);

endmodule

### rtl/ordered_set_table.sv
`timescale 1ns / 1ps
// Top level of the ordered set table: packs the stream ports around front and back.
// Depends on ost_pkg, ost_front and ost_back.
//
//   channel   direction  tuser                         tdata
//   req_      in         kind                          value, position
//   rsp_      out        success, status               read_value, element_count, is_empty
//
// The back end computes each result into the result register; the front queue accepts
// one item a cycle while not full, and the sustained rate is one item per cycle while
// rsp_tready stays high. Each item passes through the queue, then the result register.
// Reset clears the count and result valid and empties the queue; the store needs no clearing.
// A stalled result holds the back end, and the queue absorbs up to QUEUE_DEPTH items.
module ordered_set_table import ost_pkg::*; #(
   parameter int QUEUE_DEPTH = OST_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // [1:0] kind
   input  logic [39:0] req_tdata,  // [31:0] value, [35:32] position, [39:36] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,  // [0] success, [2:1] status
   output logic [39:0] rsp_tdata   // [31:0] read_value, [36:32] element_count,
                                   // [37] is_empty, [39:38] zero
);

   logic                    cmd_valid, cmd_ready;
   cmd_type                 cmd;
   logic                    success, is_empty;
   logic [OST_STATUS_W-1:0] status;
   logic [OST_VALUE_W-1:0]  read_value;
   logic [OST_COUNT_W-1:0]  element_count;

   ost_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_value    (req_tdata[31:0]),
      .req_position (req_tdata[35:32]),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd)
   );

   ost_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_success       (success),
      .rsp_status        (status),
      .rsp_read_value    (read_value),
      .rsp_element_count (element_count),
      .rsp_is_empty      (is_empty)
   );

   assign rsp_tuser = {status, success};
   assign rsp_tdata = {2'b00, is_empty, element_count, read_value};

endmodule

### rtl/ost_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ordered set table, bound to the top level.
// Depends on ost_pkg and the macros in ordered_set_table_assert.svh.
`include "ordered_set_table_assert.svh"

module ost_checker import ost_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [39:0] rsp_tdata
);

   logic                   rsp_stall;
   logic                   rsp_ok;
   logic [42:0]            rsp_word;
   logic [OST_COUNT_W-1:0] rsp_count;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_ok    = (rsp_tuser[2:1] == ST_OK);
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign rsp_count = rsp_tdata[36:32];

   `OST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   `OST_ASSERT_IMPL(a_empty_flag, clock, reset, rsp_tvalid, rsp_tdata[37] == (rsp_count == '0))
   `OST_ASSERT_IMPL(a_count_range, clock, reset, rsp_tvalid, rsp_count <= COUNT_LIMIT)
   `OST_ASSERT_IMPL(a_success_status, clock, reset, rsp_tvalid, rsp_tuser[0] == rsp_ok)
   `OST_ASSERT_IMPL(a_idle_after_reset, clock, reset, $fell(reset), !rsp_tvalid && req_tready)

   localparam logic [OST_COUNT_W-1:0] COUNT_LIMIT = OST_COUNT_W'(OST_CAPACITY);

endmodule

bind ordered_set_table ost_checker u_ost_checker (.*);
